// ===== hdl/lc3_instruction_executor_macros.svh =====
// ----------------------------------------------------------------------------
// lc3 executor assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication
`define LC3X_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LC3X_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lc3x_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3x_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lc3x_pkg;

  localparam logic [15:0] RESET_WORD  = 16'h7777;
  localparam logic [11:0] HALT_VECTOR = 12'h025;

  // request operations
  localparam logic [1:0] OPN_WRITE = 2'd0;
  localparam logic [1:0] OPN_SETPC = 2'd1;
  localparam logic [1:0] OPN_EXEC  = 2'd2;
  localparam logic [1:0] OPN_RSVD  = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_HALT    = 2'd1;
  localparam logic [1:0] STAT_ILLEGAL = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // instruction opcodes
  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RSV  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  // datapath commands
  localparam logic [3:0] DP_NOP     = 4'd0;
  localparam logic [3:0] DP_WR_IN   = 4'd1;
  localparam logic [3:0] DP_SET_PC  = 4'd2;
  localparam logic [3:0] DP_FETCH   = 4'd3;
  localparam logic [3:0] DP_DECODE  = 4'd4;
  localparam logic [3:0] DP_READ_A  = 4'd5;
  localparam logic [3:0] DP_EXEC    = 4'd6;
  localparam logic [3:0] DP_MEM1    = 4'd7;
  localparam logic [3:0] DP_MEM2    = 4'd8;
  localparam logic [3:0] DP_DUMP_RD = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic        clr_done;
    logic        stopped;
    logic [3:0]  opcode;
    logic        halt;
    logic [15:0] pc;
    logic [15:0] rf_data;
  } dp_stat_t;

endpackage

// ===== hdl/lc3x_datapath.sv =====
// ----------------------------------------------------------------------------
// lc3x_datapath
// architectural state, word memory, register file and alu
// ----------------------------------------------------------------------------
module lc3x_datapath
  import lc3x_pkg::*;
#(
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int MEM_WORDS = 1 << ADDR_WIDTH;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rf  [8];

  logic [15:0]         pc_r, pc_nxt;
  logic [15:0]         ir_r;
  logic [15:0]         a_r;
  logic [2:0]          cc_r;
  logic                stop_r;
  logic [15:0]         mem_rdata_r;
  logic [15:0]         rf_rdata_r;
  logic [7:0]          rf_vld_r;
  logic [ADDR_WIDTH:0] clr_cnt_r;

  logic [3:0]  opc;
  logic [2:0]  dr;
  logic [15:0] off9, off6, off11, imm5, alu_b, ea;
  logic        clr_done;

  logic                  mem_re, mem_we;
  logic [ADDR_WIDTH-1:0] mem_ra, mem_wa;
  logic [15:0]           mem_wd;
  logic                  rf_re, rf_we;
  logic [2:0]            rf_ra, rf_wa;
  logic [15:0]           rf_wd;
  logic                  cc_we;
  logic [2:0]            cc_nxt;
  logic                  stop_set;

  assign opc      = ir_r[15:12];
  assign dr       = ir_r[11:9];
  assign off9     = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6     = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11    = {{5{ir_r[10]}}, ir_r[10:0]};
  assign imm5     = {{11{ir_r[4]}}, ir_r[4:0]};
  assign alu_b    = ir_r[5] ? imm5 : rf_rdata_r;
  assign ea       = (opc == OPC_LDR || opc == OPC_STR) ? a_r + off6 : pc_r + off9;
  assign clr_done = clr_cnt_r[ADDR_WIDTH];

  // program counter
  always_comb begin
    pc_nxt = pc_r;
    unique case (cmd.op)
      DP_SET_PC: pc_nxt = in_data;
      DP_DECODE: pc_nxt = pc_r + 16'd1;
      DP_EXEC: begin
        unique case (opc)
          OPC_BR:  if ((ir_r[11:9] & cc_r) != 3'd0) pc_nxt = pc_r + off9;
          OPC_JSR: pc_nxt = ir_r[11] ? pc_r + off11 : a_r;
          OPC_JMP: pc_nxt = a_r;
          default: pc_nxt = pc_r;
        endcase
      end
      default: pc_nxt = pc_r;
    endcase
  end

  // register file write and condition codes
  always_comb begin
    rf_we    = 1'b0;
    rf_wa    = dr;
    rf_wd    = mem_rdata_r;
    cc_we    = 1'b0;
    stop_set = 1'b0;
    unique case (cmd.op)
      DP_EXEC: begin
        unique case (opc)
          OPC_ADD: begin rf_we = 1'b1; cc_we = 1'b1; rf_wd = a_r + alu_b; end
          OPC_AND: begin rf_we = 1'b1; cc_we = 1'b1; rf_wd = a_r & alu_b; end
          OPC_NOT: begin rf_we = 1'b1; cc_we = 1'b1; rf_wd = ~a_r; end
          OPC_LEA: begin rf_we = 1'b1; rf_wd = pc_r + off9; end
          OPC_JSR: begin rf_we = 1'b1; rf_wa = 3'd7; rf_wd = pc_r; end
          OPC_RTI, OPC_RSV, OPC_TRAP: stop_set = 1'b1;
          default: rf_we = 1'b0;
        endcase
      end
      DP_MEM1: begin
        if (opc == OPC_LD || opc == OPC_LDR) begin
          rf_we = 1'b1;
          cc_we = 1'b1;
        end
      end
      DP_MEM2: begin
        rf_we = 1'b1;
        cc_we = 1'b1;
      end
      default: rf_we = 1'b0;
    endcase
    if (rf_wd == 16'd0)  cc_nxt = 3'b010;
    else if (rf_wd[15])  cc_nxt = 3'b100;
    else                 cc_nxt = 3'b001;
  end

  // memory ports
  always_comb begin
    mem_re = 1'b0;
    mem_ra = pc_r[ADDR_WIDTH-1:0];
    mem_we = 1'b0;
    mem_wa = clr_cnt_r[ADDR_WIDTH-1:0];
    mem_wd = RESET_WORD;
    if (!clr_done) begin
      mem_we = 1'b1;
    end
    unique case (cmd.op)
      DP_WR_IN: begin
        mem_we = 1'b1;
        mem_wa = in_address[ADDR_WIDTH-1:0];
        mem_wd = in_data;
      end
      DP_FETCH: mem_re = 1'b1;
      DP_EXEC: begin
        mem_ra = ea[ADDR_WIDTH-1:0];
        mem_wa = ea[ADDR_WIDTH-1:0];
        mem_wd = rf_rdata_r;
        if (opc == OPC_LD || opc == OPC_LDR || opc == OPC_LDI || opc == OPC_STI)
          mem_re = 1'b1;
        if (opc == OPC_ST || opc == OPC_STR)
          mem_we = 1'b1;
      end
      DP_MEM1: begin
        mem_ra = mem_rdata_r[ADDR_WIDTH-1:0];
        mem_wa = mem_rdata_r[ADDR_WIDTH-1:0];
        mem_wd = rf_rdata_r;
        if (opc == OPC_LDI) mem_re = 1'b1;
        if (opc == OPC_STI) mem_we = 1'b1;
      end
      default: mem_re = 1'b0;
    endcase
  end

  // register file read port
  always_comb begin
    rf_re = 1'b1;
    rf_ra = cmd.idx;
    unique case (cmd.op)
      DP_DECODE:  rf_ra = mem_rdata_r[8:6];
      DP_READ_A:  rf_ra = (opc == OPC_ST || opc == OPC_STR || opc == OPC_STI)
                          ? ir_r[11:9] : ir_r[2:0];
      DP_DUMP_RD: rf_ra = cmd.idx;
      default:    rf_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_re) rf_rdata_r <= rf_vld_r[rf_ra] ? rf[rf_ra] : RESET_WORD;
    if (cmd.op == DP_DECODE) ir_r <= mem_rdata_r;
    if (cmd.op == DP_READ_A) a_r <= rf_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      cc_r      <= '0;
      stop_r    <= 1'b0;
      rf_vld_r  <= '0;
      clr_cnt_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cc_we) cc_r <= cc_nxt;
      if (stop_set) stop_r <= 1'b1;
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      if (!clr_done) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_done = clr_done;
  assign stat.stopped  = stop_r;
  assign stat.opcode   = opc;
  assign stat.halt     = (opc == OPC_TRAP) && (ir_r[11:0] == HALT_VECTOR);
  assign stat.pc       = pc_r;
  assign stat.rf_data  = rf_rdata_r;

endmodule

// ===== hdl/lc3x_controller.sv =====
// ----------------------------------------------------------------------------
// lc3x_controller
// sequencing state machine and result register
// ----------------------------------------------------------------------------
`include "lc3_instruction_executor_macros.svh"

module lc3x_controller
  import lc3x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_operation,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  output dp_cmd_t     cmd,
  input  dp_stat_t    stat
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_MEM1 = 4'd5;
  localparam logic [3:0] S_MEM2 = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DPUT = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  resp_r, resp_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ovld_r, ovld_nxt;
  logic [1:0]  ostat_r, ostat_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [15:0] oword_r, oword_nxt;
  logic        olast_r, olast_nxt;
  logic        out_free;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !ovld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r && !out_tready;
    ostat_nxt = ostat_r;
    oidx_nxt  = oidx_r;
    oword_nxt = oword_r;
    olast_nxt = olast_r;
    cmd.op    = DP_NOP;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_CLR: if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RESP;
          resp_nxt  = STAT_OK;
          case (in_operation)
            OPN_WRITE: cmd.op = DP_WR_IN;
            OPN_SETPC: cmd.op = DP_SET_PC;
            OPN_EXEC: begin
              if (stat.stopped) begin
                resp_nxt = STAT_IGNORED;
              end else begin
                cmd.op    = DP_FETCH;
                state_nxt = S_DEC;
              end
            end
            default: cmd.op = DP_NOP;
          endcase
        end
      end
      S_DEC: begin
        cmd.op    = DP_DECODE;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.op    = DP_READ_A;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.op    = DP_EXEC;
        resp_nxt  = STAT_OK;
        state_nxt = S_RESP;
        case (stat.opcode) inside
          OPC_LD, OPC_LDR, OPC_LDI, OPC_STI: state_nxt = S_MEM1;
          OPC_RTI, OPC_RSV: resp_nxt = STAT_ILLEGAL;
          OPC_TRAP: begin
            if (stat.halt) begin
              idx_nxt   = 3'd0;
              state_nxt = S_DRD;
            end else begin
              resp_nxt = STAT_ILLEGAL;
            end
          end
          default: resp_nxt = STAT_OK;
        endcase
      end
      S_MEM1: begin
        cmd.op    = DP_MEM1;
        state_nxt = (stat.opcode == OPC_LDI) ? S_MEM2 : S_RESP;
      end
      S_MEM2: begin
        cmd.op    = DP_MEM2;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = resp_r;
          oidx_nxt  = 3'd0;
          oword_nxt = stat.pc;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.op    = DP_DUMP_RD;
        state_nxt = S_DPUT;
      end
      S_DPUT: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = STAT_HALT;
          oidx_nxt  = idx_r;
          oword_nxt = stat.rf_data;
          olast_nxt = (idx_r == 3'd7);
          idx_nxt   = idx_r + 3'd1;
          state_nxt = (idx_r == 3'd7) ? S_IDLE : S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ovld_r  <= 1'b0;
      idx_r   <= '0;
      resp_r  <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      idx_r   <= idx_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oidx_r  <= oidx_nxt;
    oword_r <= oword_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b000, oword_r, oidx_r, ostat_r};
  assign out_tlast  = olast_r;

  `LC3X_ASSERT_IMP(a_no_accept_in_clear, in_tready, stat.clr_done,
    "word accepted before memory clear finished")
  `LC3X_ASSERT_IMP(a_dump_last_on_r7, ovld_r && ostat_r == STAT_HALT && olast_r,
    oidx_r == 3'd7, "halt dump closed on wrong register")
  `LC3X_ASSERT_IMP(a_index_zero_non_dump, ovld_r && ostat_r != STAT_HALT,
    oidx_r == 3'd0 && olast_r, "non-dump result with index or missing last")
  `LC3X_ASSERT_NXT(a_halt_starts_dump, state_r == S_EXEC && stat.halt,
    state_r == S_DRD && idx_r == 3'd0 && stat.stopped, "halt trap did not start dump")

endmodule

// ===== hdl/lc3_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// lc-3 instruction executor over a word memory, controller plus datapath
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: one word per request, write a memory word, set the
//   program counter, or execute one instruction at pc.
//   result channel out_*: one word per request, or eight words (r0..r7) for
//   a halt trap; tlast marks the final word of each request.
// sequencing:
//   memory write, pc set, ignored execute: S_RESP loads the result after accept.
//   execute: fetch, decode, register read, execute, then a memory step
//   (S_MEM1) for ld/ldr/ldi/sti and a second (S_MEM2) for ldi, set by
//   the single read port of the synchronous word memory.
//   halt dump: per register a register file read (S_DRD), then output (S_DPUT).
//   one request is in flight at a time; the next is accepted once the result
//   sits in the output register.
// reset: registers read 0x7777, pc and nzp clear, machine running; the word
//   memory is swept to 0x7777 with in_tready low.
// stall: a held result keeps the block waiting before its next output word.
// ----------------------------------------------------------------------------
module lc3_instruction_executor
  import lc3x_pkg::*;
#(
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[1:0], address[17:2], data[33:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], reg_index[4:2], word[20:5]
  output logic        out_tlast   // last
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // request fields
  logic [1:0]  in_operation;
  logic [15:0] in_address;
  logic [15:0] in_data;

  assign in_operation = in_tdata[1:0];
  assign in_address   = in_tdata[17:2];
  assign in_data      = in_tdata[33:18];

  // sequencer, owns the handshakes and the result register
  lc3x_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_operation (in_operation),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cmd          (cmd),
    .stat         (stat)
  );

  // architectural state, memory and alu
  lc3x_datapath #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_address (in_address),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== verif/lc3_exec_checker.sv =====
// ----------------------------------------------------------------------------
// lc3 executor checker
// watches both stream channels, runs its own lc-3 machine on every accepted
// request word and compares each result word against the oldest prediction
// ----------------------------------------------------------------------------
module lc3_exec_checker
  import lc3x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  reg_index;
    logic [15:0] word;
    logic        last;
  } result_t;

  result_t     result_q[$];
  logic [15:0] gpr [8];
  logic [15:0] pc;
  logic [2:0]  nzp;
  logic [15:0] mem [65536];
  bit          halted;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = (i < bits) ? v[i] : v[bits-1];
    return r;
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'h0) return 3'b010;
    else if (v[15]) return 3'b100;
    else return 3'b001;
  endfunction

  function automatic result_t single(input logic [1:0] st, input logic [15:0] w);
    result_t r;
    r.status = st; r.reg_index = 3'd0; r.word = w; r.last = 1'b1;
    return r;
  endfunction

  // one request word through the machine
  task automatic step_machine(input logic [39:0] d);
    logic [1:0]  opn;
    logic [15:0] adr, val, ir, npc;
    logic [2:0]  rd, rs1, rs2;
    logic [15:0] b;
    result_t     r;
    opn = d[1:0];
    adr = d[17:2];
    val = d[33:18];
    if (opn == OPN_WRITE) begin
      mem[adr] = val;
      result_q.push_back(single(STAT_OK, pc));
    end else if (opn == OPN_SETPC) begin
      pc = val;
      result_q.push_back(single(STAT_OK, pc));
    end else if (opn != OPN_EXEC) begin
      result_q.push_back(single(STAT_OK, pc));
    end else if (halted) begin
      result_q.push_back(single(STAT_IGNORED, pc));
    end else begin
      ir  = mem[pc];
      pc  = pc + 16'd1;
      npc = pc;
      rd  = ir[11:9];
      rs1 = ir[8:6];
      rs2 = ir[2:0];
      b   = ir[5] ? sx(ir, 5) : gpr[rs2];
      case (ir[15:12])
        OPC_BR:  if ((ir[11:9] & nzp) != 3'b0) pc = npc + sx(ir, 9);
        OPC_ADD: begin gpr[rd] = gpr[rs1] + b; nzp = flags_of(gpr[rd]); end
        OPC_AND: begin gpr[rd] = gpr[rs1] & b; nzp = flags_of(gpr[rd]); end
        OPC_NOT: begin gpr[rd] = ~gpr[rs1]; nzp = flags_of(gpr[rd]); end
        OPC_LD:  begin gpr[rd] = mem[npc + sx(ir, 9)]; nzp = flags_of(gpr[rd]); end
        OPC_LDR: begin gpr[rd] = mem[gpr[rs1] + sx(ir, 6)]; nzp = flags_of(gpr[rd]); end
        OPC_LDI: begin gpr[rd] = mem[mem[npc + sx(ir, 9)]]; nzp = flags_of(gpr[rd]); end
        OPC_ST:  mem[npc + sx(ir, 9)] = gpr[rd];
        OPC_STR: mem[gpr[rs1] + sx(ir, 6)] = gpr[rd];
        OPC_STI: mem[mem[npc + sx(ir, 9)]] = gpr[rd];
        OPC_JSR: begin
          pc = ir[11] ? npc + sx(ir, 11) : gpr[rs1];
          gpr[7] = npc;
        end
        OPC_JMP: pc = gpr[rs1];
        OPC_LEA: gpr[rd] = npc + sx(ir, 9);
        default: begin
          halted = 1'b1;
          if (ir[15:12] == OPC_TRAP && ir[11:0] == HALT_VECTOR) begin
            for (int t = 0; t < 8; t++) begin
              r.status = STAT_HALT; r.reg_index = t[2:0];
              r.word = gpr[t]; r.last = (t == 7);
              result_q.push_back(r);
            end
          end else begin
            result_q.push_back(single(STAT_ILLEGAL, pc));
          end
        end
      endcase
      if (!halted) result_q.push_back(single(STAT_OK, pc));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) gpr[i] = RESET_WORD;
      for (int i = 0; i < 65536; i++) mem[i] = RESET_WORD;
      pc = 16'h0; nzp = 3'b0; halted = 1'b0;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report($sformatf("unexpected result word %h", out_tdata));
        end else begin
          result_t e;
          e = result_q.pop_front();
          if (out_tdata[1:0] != e.status)
            report($sformatf("status %0d, wanted %0d", out_tdata[1:0], e.status));
          if (out_tdata[4:2] != e.reg_index)
            report($sformatf("reg_index %0d, wanted %0d", out_tdata[4:2], e.reg_index));
          if (out_tdata[20:5] != e.word)
            report($sformatf("word %h, wanted %h", out_tdata[20:5], e.word));
          if (out_tlast != e.last)
            report($sformatf("last %0d, wanted %0d", out_tlast, e.last));
        end
      end
      if (in_tvalid && in_tready) step_machine(in_tdata);
    end
    outstanding = result_q.size();
  end

endmodule

// ===== verif/lc3_instruction_executor_test.sv =====
// ----------------------------------------------------------------------------
// lc3 instruction executor testbench
// drives a directed lc-3 program, then random write/set-pc/execute traffic,
// and finally one stopping instruction; the checker predicts and compares
// ----------------------------------------------------------------------------
module lc3_instruction_executor_test;
  import lc3x_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // operation[1:0], address[17:2], data[33:18]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // status[1:0], reg_index[4:2], word[20:5]
  logic        out_tlast;   // last
  int          fail_count;
  int          outstanding;

  // request word accepted at the last rising edge
  logic        in_acc;
  // no idling on either side while set
  bit          steady;
  // asks the receiver for one long hold-off
  bit          hold_go;
  int          sent;

  lc3_instruction_executor uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  lc3_exec_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) in_acc <= in_tvalid && in_tready;

  // hard stop: memory sweep after reset plus a slow worst case, many times over
  initial begin
    #16000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        hold = 0;
        out_tready <= 1'b0;
        // block stays full, sender keeps offering meanwhile
        while (hold < 120) begin
          @(negedge clk);
          hold++;
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 21);
      @(negedge clk);
    end
  end

  // one request word, with a random gap ahead of it
  task automatic send(input logic [1:0] opn, input logic [15:0] adr,
                      input logic [15:0] val);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, adr, opn};
    do @(negedge clk); while (!in_acc);
    sent++;
  endtask

  // place one instruction at a and run it from there
  task automatic run_at(input logic [15:0] a, input logic [15:0] instr);
    send(OPN_SETPC, 16'h0, a);
    send(OPN_WRITE, a, instr);
    send(OPN_EXEC, 16'($urandom), 16'($urandom));
  endtask

  // directed program at 0x3000, runs straight through with one subroutine hop
  logic [15:0] prog [13] = '{
    16'h1270,   // add r1, r1, #-16
    16'h5460,   // and r2, r1, #0, zero flag
    16'h96BF,   // not r3, r2, negative flag
    16'h18C1,   // add r4, r3, r1, register form
    16'hABFB,   // ldi r5, pointer back into the program
    16'hB6FF,   // sti r3, largest positive offset
    16'hED00,   // lea r6, most negative offset
    16'h01FF,   // br with no flags never branches
    16'h4801,   // jsr +1, skips one word
    16'h31FF,   // st r0, back one
    16'h61A0,   // ldr r0, r6, #-32
    16'h78DF,   // str r4, r3, #31
    16'hC1C0    // jmp r7, returns to the skipped word
  };

  initial begin
    logic [3:0]  legal [12] = '{OPC_BR, OPC_ADD, OPC_LD, OPC_ST, OPC_JSR, OPC_AND,
                                OPC_LDR, OPC_STR, OPC_NOT, OPC_LDI, OPC_STI, OPC_LEA};
    logic [15:0] a, instr;
    logic [11:0] vec;
    int          r;
    bit          hold_done;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    steady     = 1'b0;
    hold_go    = 1'b0;
    hold_done  = 1'b0;
    sent       = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed part
    send(OPN_RSVD, 16'hFFFF, 16'hFFFF);      // unused operation code
    send(OPN_WRITE, 16'hFFFF, 16'hFFFF);
    send(OPN_WRITE, 16'h0000, 16'h0000);
    for (int i = 0; i < 13; i++) send(OPN_WRITE, 16'(16'h3000 + i), prog[i]);
    send(OPN_SETPC, 16'h0, 16'h3000);
    for (int i = 0; i < 15; i++) send(OPN_EXEC, 16'h0, 16'h0);

    // random part: mostly placed instructions, some data writes and noise
    while (sent < 100) begin
      if (sent >= 55 && sent < 85) steady = 1'b1;
      else steady = 1'b0;
      if (sent >= 40 && !hold_done) begin
        hold_go   = 1'b1;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        a = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'(16'h3000 + $urandom_range(0, 255));
        instr = {legal[$urandom_range(0, 11)], 12'($urandom)};
        run_at(a, instr);
      end else if (r < 85) begin
        // data near the program region so loads see it
        a = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                        : 16'(16'h3000 + $urandom_range(0, 511));
        send(OPN_WRITE, a, 16'($urandom));
      end else if (r < 93) begin
        send(OPN_SETPC, 16'($urandom), 16'($urandom));
      end else begin
        send(OPN_RSVD, 16'($urandom), 16'($urandom));
      end
    end
    steady = 1'b0;

    // the machine stops for good: halt dump or one of the illegal forms
    vec = 12'($urandom);
    if (vec == HALT_VECTOR) vec = 12'h0FF;
    case ($urandom_range(0, 3))
      0, 1: instr = {OPC_TRAP, HALT_VECTOR};
      2:    instr = {OPC_RTI, 12'($urandom)};
      default: instr = ($urandom_range(0, 1) == 0) ? {OPC_RSV, 12'($urandom)}
                                                  : {OPC_TRAP, vec};
    endcase
    run_at(16'(16'h3000 + $urandom_range(0, 255)), instr);
    send(OPN_EXEC, 16'h0, 16'h0);            // ignored while stopped
    send(OPN_WRITE, 16'h1234, 16'hABCD);
    send(OPN_SETPC, 16'h0, 16'h3000);
    send(OPN_EXEC, 16'h0, 16'h0);
    send(OPN_RSVD, 16'h0, 16'h0);
    in_tvalid <= 1'b0;

    // drain, then a few more cycles for anything stray
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
